// File: hdl/icmp_echo_pkg.sv
// Shared constants, types and helper functions for the ICMP echo reply builder.
package icmp_echo_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int LEN_W       = 17;

  localparam int MAC_W       = 48;
  localparam int IP_W        = 32;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 1;

  localparam int MIN_FRAME   = 38;
  localparam int ETH_HDR     = 14;

  localparam logic [7:0]  ECHO_REQUEST  = 8'h08;
  localparam logic [7:0]  ECHO_REPLY    = 8'h00;
  localparam logic [15:0] TYPE_WORD_REQ = 16'h0800;

  // frame byte positions
  localparam int POS_LEN_HI = 16;
  localparam int POS_LEN_LO = 17;
  localparam int POS_SRC_IP = 26;
  localparam int POS_DST_IP = 30;
  localparam int POS_TYPE   = 34;
  localparam int POS_CKS_HI = 36;
  localparam int POS_CKS_LO = 37;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 1'b1;

  typedef enum logic [1:0] {
    OC_REPLY    = 2'd0,
    OC_NOT_ECHO = 2'd1,
    OC_NOT_OURS = 2'd2,
    OC_LEN_ERR  = 2'd3
  } outcome_t;

  typedef enum logic [2:0] {
    ST_RECV = 3'b001,
    ST_EVAL = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  // Store entry that feeds reply byte i.
  function automatic logic [ADDR_W-1:0] src_index(input logic [CNT_W-1:0] i);
    logic [CNT_W-1:0] s;
    if (i < CNT_W'(6)) begin
      s = i + CNT_W'(6);
    end else if (i >= CNT_W'(POS_DST_IP) && i < CNT_W'(POS_TYPE)) begin
      s = i - CNT_W'(4);
    end else begin
      s = i;
    end
    return s[ADDR_W-1:0];
  endfunction

  // RFC 1624 update for the type word going from request to reply.
  function automatic logic [15:0] csum_update(input logic [15:0] hc);
    logic [16:0] sum;
    logic [15:0] fold;
    sum  = {1'b0, ~hc} + {1'b0, ~TYPE_WORD_REQ};
    fold = sum[15:0] + 16'(sum[16]);
    return ~fold;
  endfunction

endpackage

// File: hdl/icmp_echo_reply_builder.sv
// Top level: buffers a received frame and answers ICMP echo requests.
//
// Frame bytes are taken at one word per cycle into a 64-entry frame store; header
// fields needed for the checks are captured as they pass. After the word marked
// as frame end the input stalls: the frame is evaluated, then either one
// status word or the reply is sent, one word per cycle while the output is not
// stalled (the store read of the next byte overlaps the hand-off of the current
// one). Bytes beyond 64 are dropped and mark the frame as a length error. Writes
// to the store occur only while receiving and reads only while evaluating or
// sending, so the two never touch the same entry in the same cycle.
module icmp_echo_reply_builder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_frame_byte,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_reply_byte,
  output logic                                 out_reply_end,
  output logic [1:0]                           out_outcome,
  input  logic                                 cfg_we,
  input  logic [icmp_echo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icmp_echo_pkg::CFG_W-1:0]      cfg_wdata
);
  import icmp_echo_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [15:0]        csum_r, csum_nxt;
  logic [MAC_W-1:0]   own_mac_r;
  logic [IP_W-1:0]    own_ip_r;

  // captured header bytes
  logic [7:0]         len_hi_r, len_lo_r, type_r, cks_hi_r, cks_lo_r;
  logic [IP_W-1:0]    dst_ip_r;

  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_end_r, out_end_nxt;
  outcome_t           out_outcome_r, out_outcome_nxt;

  logic               in_acc, can_load, store_wr;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;
  logic [LEN_W-1:0]   reply_len;
  outcome_t           verdict;
  logic [7:0]         send_byte;
  logic               send_last;

  assign in_stall = (state_r != ST_RECV);
  assign in_acc   = in_valid && !in_stall;
  assign can_load = !out_valid_r || !out_stall;
  assign store_wr = in_acc && (count_r < CNT_W'(FRAME_BYTES));

  icmp_echo_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store_wr),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_frame_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Frame checks, in priority order.
  always_comb begin
    reply_len = LEN_W'(ETH_HDR) + {1'b0, len_hi_r, len_lo_r};
    if (ovf_r || count_r < CNT_W'(MIN_FRAME)) begin
      verdict = OC_LEN_ERR;
    end else if (type_r != ECHO_REQUEST) begin
      verdict = OC_NOT_ECHO;
    end else if (dst_ip_r != own_ip_r) begin
      verdict = OC_NOT_OURS;
    end else if (reply_len < LEN_W'(MIN_FRAME) || reply_len > LEN_W'(count_r)) begin
      verdict = OC_LEN_ERR;
    end else begin
      verdict = OC_REPLY;
    end
  end

  // Reply byte for the current index.
  always_comb begin
    unique case (idx_r)
      CNT_W'(6):  send_byte = own_mac_r[47:40];
      CNT_W'(7):  send_byte = own_mac_r[39:32];
      CNT_W'(8):  send_byte = own_mac_r[31:24];
      CNT_W'(9):  send_byte = own_mac_r[23:16];
      CNT_W'(10): send_byte = own_mac_r[15:8];
      CNT_W'(11): send_byte = own_mac_r[7:0];
      CNT_W'(POS_SRC_IP):     send_byte = own_ip_r[31:24];
      CNT_W'(POS_SRC_IP + 1): send_byte = own_ip_r[23:16];
      CNT_W'(POS_SRC_IP + 2): send_byte = own_ip_r[15:8];
      CNT_W'(POS_SRC_IP + 3): send_byte = own_ip_r[7:0];
      CNT_W'(POS_TYPE):       send_byte = ECHO_REPLY;
      CNT_W'(POS_CKS_HI):     send_byte = csum_r[15:8];
      CNT_W'(POS_CKS_LO):     send_byte = csum_r[7:0];
      default:                send_byte = ram_rdata;
    endcase
    send_last = (idx_r == len_r - CNT_W'(1));
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    ovf_nxt         = ovf_r;
    idx_nxt         = idx_r;
    len_nxt         = len_r;
    csum_nxt        = csum_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_byte_nxt    = out_byte_r;
    out_end_nxt     = out_end_r;
    out_outcome_nxt = out_outcome_r;
    ram_re          = 1'b0;
    ram_raddr       = src_index(idx_r);

    unique case (state_r)
      ST_RECV: begin
        if (in_acc) begin
          if (store_wr) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_frame_end) begin
            state_nxt = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (verdict != OC_REPLY) begin
          // hold until the output register frees up
          if (can_load) begin
            out_valid_nxt   = 1'b1;
            out_byte_nxt    = 8'h00;
            out_end_nxt     = 1'b1;
            out_outcome_nxt = verdict;
            count_nxt       = '0;
            ovf_nxt         = 1'b0;
            state_nxt       = ST_RECV;
          end
        end else begin
          len_nxt   = reply_len[CNT_W-1:0];
          csum_nxt  = csum_update({cks_hi_r, cks_lo_r});
          idx_nxt   = '0;
          ram_re    = 1'b1;
          ram_raddr = src_index('0);
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (can_load) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = send_byte;
          out_end_nxt     = send_last;
          out_outcome_nxt = OC_REPLY;
          if (send_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_RECV;
          end else begin
            // advance and fetch the next byte in the same cycle
            idx_nxt   = idx_r + CNT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = src_index(idx_r + CNT_W'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RECV;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      own_mac_r   <= '0;
      own_ip_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OWN_MAC: own_mac_r <= cfg_wdata[MAC_W-1:0];
          REG_OWN_IP:  own_ip_r  <= cfg_wdata[IP_W-1:0];
          default:     own_ip_r  <= own_ip_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    len_r         <= len_nxt;
    csum_r        <= csum_nxt;
    out_byte_r    <= out_byte_nxt;
    out_end_r     <= out_end_nxt;
    out_outcome_r <= out_outcome_nxt;
    // capture header fields as they are stored
    if (store_wr) begin
      if (count_r == CNT_W'(POS_LEN_HI))     len_hi_r         <= in_frame_byte;
      if (count_r == CNT_W'(POS_LEN_LO))     len_lo_r         <= in_frame_byte;
      if (count_r == CNT_W'(POS_DST_IP))     dst_ip_r[31:24]  <= in_frame_byte;
      if (count_r == CNT_W'(POS_DST_IP + 1)) dst_ip_r[23:16]  <= in_frame_byte;
      if (count_r == CNT_W'(POS_DST_IP + 2)) dst_ip_r[15:8]   <= in_frame_byte;
      if (count_r == CNT_W'(POS_DST_IP + 3)) dst_ip_r[7:0]    <= in_frame_byte;
      if (count_r == CNT_W'(POS_TYPE))       type_r           <= in_frame_byte;
      if (count_r == CNT_W'(POS_CKS_HI))     cks_hi_r         <= in_frame_byte;
      if (count_r == CNT_W'(POS_CKS_LO))     cks_lo_r         <= in_frame_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_byte = out_byte_r;
  assign out_reply_end  = out_end_r;
  assign out_outcome    = out_outcome_r;

  // A new result word only appears after the frame was evaluated.
  a_word_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) != ST_RECV)
    else $error("result word appeared while receiving");

  // The send index stays within the reply.
  a_idx_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND |-> idx_r < len_r)
    else $error("send index beyond reply length");

  // Store reads only touch entries written in this frame.
  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> CNT_W'(ram_raddr) < count_r)
    else $error("read of a store entry not written in this frame");

  // A status word always closes its run.
  a_status_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_outcome_r != OC_REPLY |-> out_end_r && out_byte_r == 8'h00)
    else $error("status word without end mark");

endmodule

// File: hdl/icmp_echo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module icmp_echo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
